### rtl/sslms_pkg.sv
`timescale 1ns / 1ps
// shared constants and controller/datapath interface types for the sign-sign lms predictor
package sslms_pkg;

  localparam int MAX_TAPS  = 32;
  localparam int ADDR_W    = $clog2(MAX_TAPS);
  localparam int TAPS_W    = 6;
  localparam int SAMPLE_W  = 24;
  localparam int RES_W     = 25;
  localparam int WEIGHT_W  = 32;
  localparam int PRED_W    = 32;
  localparam int PROD_W    = WEIGHT_W + SAMPLE_W;
  localparam int SHIFT_16  = 9;
  localparam int SHIFT_24  = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = TAPS_W;

  localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PCM_24_BIT  = 1'd1;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct packed {
    logic              start;
    logic              clr_mem;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              load_out;
    logic              pcm_24_bit;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } stat_t;

endpackage

### rtl/sslms_datapath.sv
`timescale 1ns / 1ps
// tap memories, weight update, multiply and accumulate pipeline
module sslms_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  sslms_pkg::cmd_t                     cmd,
  output sslms_pkg::stat_t                    stat,
  input  logic signed [sslms_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [sslms_pkg::RES_W-1:0]    residual,
  output logic signed [sslms_pkg::PRED_W-1:0]   prediction
);

  logic [sslms_pkg::SAMPLE_W-1:0] hist_mem [sslms_pkg::MAX_TAPS];
  logic [sslms_pkg::WEIGHT_W-1:0] w_mem    [sslms_pkg::MAX_TAPS];
  logic [sslms_pkg::MAX_TAPS-1:0] entry_ok;

  logic signed [sslms_pkg::SAMPLE_W-1:0] sample_q;
  logic                                  res_pos;
  logic                                  res_neg;

  logic [sslms_pkg::SAMPLE_W-1:0] hist_rd;
  logic [sslms_pkg::WEIGHT_W-1:0] w_rd;
  logic                           rd_ok;
  logic                           rd_v;
  logic [sslms_pkg::ADDR_W-1:0]   rd_addr_q;
  logic [sslms_pkg::SAMPLE_W-1:0] prev_h;

  logic [sslms_pkg::SAMPLE_W-1:0] old_h;
  logic [sslms_pkg::WEIGHT_W-1:0] old_w;
  logic [sslms_pkg::WEIGHT_W-1:0] delta;
  logic [sslms_pkg::WEIGHT_W-1:0] new_w;
  logic [sslms_pkg::SAMPLE_W-1:0] new_h;
  logic                           h_pos;
  logic                           h_neg;

  logic signed [sslms_pkg::WEIGHT_W-1:0] ma;
  logic signed [sslms_pkg::SAMPLE_W-1:0] mb;
  logic                                  m_v;
  logic signed [sslms_pkg::PROD_W-1:0]   prod;
  logic                                  p_v;
  logic [sslms_pkg::PRED_W-1:0]          acc;
  logic [sslms_pkg::PRED_W-1:0]          term;

  // entries never written since the last clear read as zero
  assign old_h = rd_ok ? hist_rd : '0;
  assign old_w = rd_ok ? w_rd : '0;
  assign h_neg = old_h[sslms_pkg::SAMPLE_W-1];
  assign h_pos = (old_h != '0) && !h_neg;

  always_comb begin
    if ((res_pos && h_pos) || (res_neg && h_neg)) begin
      delta = sslms_pkg::WEIGHT_W'(1);
    end else if ((res_pos && h_neg) || (res_neg && h_pos)) begin
      delta = '1;
    end else begin
      delta = '0;
    end
  end

  assign new_w = old_w + delta;
  // tap 0 takes the new sample, every other tap the old value of its neighbour
  assign new_h = (rd_addr_q == '0) ? sample_q : prev_h;

  assign term = cmd.pcm_24_bit ? prod[sslms_pkg::SHIFT_24 +: sslms_pkg::PRED_W]
                               : prod[sslms_pkg::SHIFT_16 +: sslms_pkg::PRED_W];

  assign stat.pipe_busy = rd_v | m_v | p_v;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      hist_rd <= hist_mem[cmd.rd_addr];
      w_rd    <= w_mem[cmd.rd_addr];
    end
    if (rd_v) begin
      hist_mem[rd_addr_q] <= new_h;
      w_mem[rd_addr_q]    <= new_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ok <= '0;
      rd_v     <= 1'b0;
      m_v      <= 1'b0;
      p_v      <= 1'b0;
      rd_ok    <= 1'b0;
    end else begin
      if (cmd.clr_mem) begin
        entry_ok <= '0;
      end else if (rd_v) begin
        entry_ok[rd_addr_q] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_ok <= entry_ok[cmd.rd_addr];
      end
      rd_v <= cmd.rd_en;
      m_v  <= rd_v;
      p_v  <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sample_q <= sample;
      res_neg  <= residual[sslms_pkg::RES_W-1];
      res_pos  <= (residual != '0) && !residual[sslms_pkg::RES_W-1];
    end
    if (cmd.rd_en) begin
      rd_addr_q <= cmd.rd_addr;
    end
    if (rd_v) begin
      prev_h <= old_h;
      ma     <= new_w;
      mb     <= new_h;
    end
    prod <= ma * mb;
    if (cmd.start) begin
      acc <= '0;
    end else if (p_v) begin
      acc <= acc + term;
    end
    if (cmd.load_out) begin
      prediction <= acc;
    end
  end

endmodule

### rtl/sslms_controller.sv
`timescale 1ns / 1ps
// configuration registers, handshakes and tap sequencing
module sslms_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [sslms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sslms_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sslms_pkg::cmd_t                      cmd,
  input  sslms_pkg::stat_t                     stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t                      state;
  logic [sslms_pkg::TAPS_W-1:0] taps_in_use;
  logic                        pcm_24_bit;
  logic [sslms_pkg::TAPS_W-1:0] n_act;
  logic [sslms_pkg::TAPS_W-1:0] cnt;
  logic [sslms_pkg::TAPS_W-1:0] cnt_next;
  logic [sslms_pkg::TAPS_W-1:0] n_clip;
  logic                        accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cnt_next = cnt + sslms_pkg::TAPS_W'(1);
  assign n_clip   = (taps_in_use > sslms_pkg::TAPS_W'(sslms_pkg::MAX_TAPS))
                    ? sslms_pkg::TAPS_W'(sslms_pkg::MAX_TAPS) : taps_in_use;

  always_comb begin
    cmd            = '0;
    cmd.pcm_24_bit = pcm_24_bit;
    cmd.rd_addr    = cnt[sslms_pkg::ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        cmd.start   = accept;
        cmd.clr_mem = accept && (kind == sslms_pkg::KIND_CLEAR);
      end
      S_ISSUE: begin
        cmd.rd_en = 1'b1;
      end
      S_OUT: begin
        cmd.load_out = !out_valid || out_ready;
      end
      default: begin
        cmd.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      taps_in_use <= sslms_pkg::TAPS_W'(sslms_pkg::MAX_TAPS);
      pcm_24_bit  <= 1'b0;
      out_valid   <= 1'b0;
      cnt         <= '0;
      n_act       <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sslms_pkg::REG_TAPS_IN_USE: taps_in_use <= cfg_data[sslms_pkg::TAPS_W-1:0];
          sslms_pkg::REG_PCM_24_BIT:  pcm_24_bit  <= cfg_data[0];
          default:                    pcm_24_bit  <= pcm_24_bit;
        endcase
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            n_act <= n_clip;
            // clear words and a zero tap count skip the tap sweep
            if ((kind == sslms_pkg::KIND_CLEAR) || (n_clip == '0)) begin
              state <= S_OUT;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          cnt <= cnt_next;
          if (cnt_next == n_act) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!stat.pipe_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/sign_sign_lms_predictor_top.sv
`timescale 1ns / 1ps
// Sign-sign LMS audio predictor: one input word (update or clear) gives one prediction word.
// An update word adapts each active tap weight by sign(residual) times sign(history), shifts
// the history line and returns the next prediction; a clear word zeroes history and weights
// and returns 0. Taps are swept one per cycle through a read port and a write port on each
// tap memory, followed by a three-stage update, multiply and accumulate pipeline. An update
// word passes through S_ISSUE, S_DRAIN and S_OUT (a tap count above 32 acts as 32); a clear
// word or a zero tap count goes from S_IDLE straight to S_OUT. S_OUT loads the result into
// the output register once that register is free, and the next input word can be taken in
// the cycle after that. One word is worked on at a time; the next input word is taken as soon
// as the result is in the output register, even if it has not yet been taken.
// Configuration writes (taps_in_use at index 0, pcm_24_bit at index 1) take effect at once
// and must only be issued while the block is idle.
module sign_sign_lms_predictor_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [sslms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sslms_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic signed [sslms_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [sslms_pkg::RES_W-1:0]    residual,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sslms_pkg::PRED_W-1:0]   prediction
);

  sslms_pkg::cmd_t  cmd;
  sslms_pkg::stat_t stat;

  sslms_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sslms_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .sample     (sample),
    .residual   (residual),
    .prediction (prediction)
  );

  // a word is only taken with the tap pipeline empty
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.pipe_busy)
    else $error("input taken while tap pipeline busy");

  // the block is busy in the cycle after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after accepting a word");

  // a result appears only when the output register was loaded
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("out_valid rose without an output load");

  // no tap reads are issued while a result is being loaded
  a_no_read_on_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!cmd.rd_en && !stat.pipe_busy))
    else $error("output loaded while taps still in flight");

endmodule
